// ----- rtl/fpfc_pkg.sv -----
// shared types and constants for the foot pressure filter core
// no dependencies

package fpfc_pkg;

    localparam int NCH       = 4;
    localparam int WINDOW    = 8;
    localparam int SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W     = 24 + $clog2(WINDOW) + 1;
    localparam int COP_MIN_TOTAL = 256;
    localparam int COP_X_UM  = 85000;
    localparam int COP_Y_UM  = 45000;
    localparam int DIV_W     = 43;  // magnitude of numerator * 85000
    localparam int CH_W      = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHAN,
        ST_DIVX,
        ST_DIVY,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic              start;
        logic              sign;
        logic [DIV_W-1:0]  num;
        logic [24:0]       den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_W-1:0]  quo;
    } div_rsp_t;

endpackage

// ----- rtl/fpfc_div.sv -----
// radix-2 restoring divider for the center of pressure quotients
// uses fpfc_pkg; one quotient bit per cycle, result truncated toward zero

module fpfc_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  fpfc_pkg::div_req_t  req,
    output fpfc_pkg::div_rsp_t  rsp
);

    localparam int CNT_W = $clog2(fpfc_pkg::DIV_W + 1);

    logic [fpfc_pkg::DIV_W-1:0] quo_reg, quo_next;
    logic [24:0]                rem_reg, rem_next;
    logic [24:0]                den_reg, den_next;
    logic                       sign_reg, sign_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [25:0]                trial;
    logic [fpfc_pkg::DIV_W-1:0] mag;

    // one shift-subtract step per cycle
    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        sign_next = sign_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[fpfc_pkg::DIV_W-1]};
        if (req.start) begin
            quo_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
            sign_next = req.sign;
            cnt_next  = CNT_W'(fpfc_pkg::DIV_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[fpfc_pkg::DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg}) begin
                rem_next    = 25'(trial - {1'b0, den_reg});
                quo_next[0] = 1'b1;
            end else begin
                rem_next = trial[24:0];
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        sign_reg <= sign_next;
    end

    assign mag      = quo_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = sign_reg ? (~mag + 1'b1) : mag;

endmodule

// ----- rtl/fpfc_chan.sv -----
// per-channel correction: offset, gain, floor shift, saturation
// uses fpfc_pkg; registered product, then shift and clamp

module fpfc_chan (
    input  logic                aclk,
    input  logic signed [23:0]  raw,
    input  logic signed [23:0]  zero,
    input  logic signed [23:0]  gain,
    output logic signed [23:0]  corr
);

    logic signed [24:0] diff;
    logic signed [48:0] prod_reg;
    logic signed [32:0] shifted;

    assign diff = 25'(raw) - 25'(zero);

    // product register
    always_ff @(posedge aclk) begin
        prod_reg <= diff * 49'(gain);
    end

    // arithmetic shift floors; then saturate
    assign shifted = 33'(prod_reg >>> 16);
    always_comb begin
        if (shifted > 33'sd8388607)
            corr = 24'sd8388607;
        else if (shifted < -33'sd8388608)
            corr = -24'sd8388608;
        else
            corr = shifted[23:0];
    end

endmodule

// ----- rtl/foot_pressure_filter_cop_core.sv -----
// top level of the foot pressure filter with center of pressure
// uses fpfc_pkg, fpfc_chan, fpfc_div
//
// Each input beat carries four raw load-cell samples and yields one result beat. Samples are
// corrected by zero offset and gain, written into a ring memory of WINDOW entries (all four
// channels in one 96-bit word) that is read and written back once per item, and averaged via
// per-channel running sums. Channels go through one shared multiplier, one per cycle. The two
// COP quotients come from a shared bit-serial divider, 43 steps each, and are computed only
// for an item whose total is above the threshold; the next input beat is taken from the cycle
// the result is registered. A result waits in its own output register, so one further item
// can be worked on while the receiver stalls. After reset a clearing pass over all WINDOW
// entries zeroes the ring before the first input beat is taken. The user must write
// configuration only while no item is in flight; the block itself does not enforce this.

module foot_pressure_filter_cop_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [23:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // raw_left_front, raw_left_back, raw_right_front, raw_right_back
    input  logic [95:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // force_left_front, force_left_back, force_right_front, force_right_back,
    // force_total, cop_x, cop_y
    output logic [151:0] m_tdata,
    // cop_valid
    output logic         m_tuser
);

    localparam int SW = fpfc_pkg::SLOT_W;
    localparam int CW = fpfc_pkg::CH_W;

    // configuration registers
    logic [23:0] zero_reg [fpfc_pkg::NCH];
    logic [23:0] gain_reg [fpfc_pkg::NCH];

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < fpfc_pkg::NCH; i++) begin
                zero_reg[i] <= '0;
                gain_reg[i] <= 24'd65536;
            end
        end else if (cfg_valid) begin
            if (cfg_index[2]) gain_reg[cfg_index[1:0]] <= cfg_data;
            else              zero_reg[cfg_index[1:0]] <= cfg_data;
        end
    end

    // control state
    fpfc_pkg::state_t state_reg, state_next;
    logic [SW-1:0]  slot_reg, slot_next;
    logic [SW:0]    clr_reg, clr_next;
    logic [CW:0]    ch_reg, ch_next;
    logic [95:0]    in_reg;
    logic [95:0]    old_reg;
    logic [95:0]    new_reg;
    logic signed [fpfc_pkg::SUM_W-1:0] sum_reg [fpfc_pkg::NCH];
    logic [22:0]    f_reg [fpfc_pkg::NCH];
    logic [24:0]    total_reg;
    logic [17:0]    cx_reg;
    logic [16:0]    cy_reg;
    logic           cv_reg;
    logic           out_valid_reg;
    logic [151:0]   out_data_reg;
    logic           out_user_reg;

    // ring memory
    logic [95:0]   ring_mem [fpfc_pkg::WINDOW];
    logic [95:0]   ring_rd;
    logic [95:0]   ring_wdata;
    logic [SW-1:0] ring_waddr;
    logic          ring_we;

    always_ff @(posedge aclk) begin
        if (ring_we) ring_mem[ring_waddr] <= ring_wdata;
        ring_rd <= ring_mem[slot_reg];
    end

    // shared channel datapath
    logic [CW-1:0]      ch_idx;
    logic signed [23:0] corr;
    logic signed [23:0] old_s;
    logic signed [fpfc_pkg::SUM_W-1:0] sum_new;
    logic signed [fpfc_pkg::SUM_W-1:0] avg;

    assign ch_idx = ch_reg[CW-1:0] - 1'b1;

    fpfc_chan u_chan (
        .aclk (aclk),
        .raw  (in_reg[24*ch_reg[CW-1:0] +: 24]),
        .zero (zero_reg[ch_reg[CW-1:0]]),
        .gain (gain_reg[ch_reg[CW-1:0]]),
        .corr (corr)
    );

    assign old_s   = old_reg[24*ch_idx +: 24];
    assign sum_new = sum_reg[ch_idx] + fpfc_pkg::SUM_W'(corr) - fpfc_pkg::SUM_W'(old_s);
    assign avg     = fpfc_pkg::SUM_W'(sum_new / fpfc_pkg::WINDOW);

    // cop numerators
    logic signed [25:0] nx, ny;
    assign nx = 26'(f_reg[0]) + 26'(f_reg[2]) - 26'(f_reg[1]) - 26'(f_reg[3]);
    assign ny = 26'(f_reg[0]) + 26'(f_reg[1]) - 26'(f_reg[2]) - 26'(f_reg[3]);

    logic [25:0]  nx_mag_c, ny_mag_c;
    logic [42:0]  numx, numy;
    assign nx_mag_c = nx[25] ? 26'(-nx) : 26'(nx);
    assign ny_mag_c = ny[25] ? 26'(-ny) : 26'(ny);
    assign numx = 43'(nx_mag_c) * 43'(fpfc_pkg::COP_X_UM);
    assign numy = 43'(ny_mag_c) * 43'(fpfc_pkg::COP_Y_UM);

    fpfc_pkg::div_req_t dreq;
    fpfc_pkg::div_rsp_t drsp;

    fpfc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    logic signed [42:0] q;
    logic [17:0] cx_clamp;
    logic [16:0] cy_clamp;
    assign q = drsp.quo;
    always_comb begin
        if (q > 43'sd85000)       cx_clamp = 18'd85000;
        else if (q < -43'sd85000) cx_clamp = 18'(-85000);
        else                      cx_clamp = q[17:0];
        if (q > 43'sd45000)       cy_clamp = 17'd45000;
        else if (q < -43'sd45000) cy_clamp = 17'(-45000);
        else                      cy_clamp = q[16:0];
    end

    logic accept_in;
    assign s_tready  = (state_reg == fpfc_pkg::ST_IDLE) && !clr_reg[SW];
    assign accept_in = s_tvalid && s_tready;

    // sequencer
    always_comb begin
        state_next = state_reg;
        slot_next  = slot_reg;
        clr_next   = clr_reg;
        ch_next    = ch_reg;
        ring_we    = 1'b0;
        ring_waddr = slot_reg;
        ring_wdata = new_reg;
        dreq.start = 1'b0;
        dreq.sign  = nx[25];
        dreq.num   = numx;
        dreq.den   = total_reg;
        unique case (state_reg)
            fpfc_pkg::ST_IDLE: begin
                if (clr_reg[SW]) begin
                    ring_we    = 1'b1;
                    ring_waddr = clr_reg[SW-1:0];
                    ring_wdata = '0;
                    if (clr_reg[SW-1:0] == SW'(fpfc_pkg::WINDOW - 1)) clr_next = '0;
                    else clr_next = clr_reg + 1'b1;
                end else if (accept_in) begin
                    state_next = fpfc_pkg::ST_READ;
                end
            end
            fpfc_pkg::ST_READ: begin
                ch_next    = '0;
                state_next = fpfc_pkg::ST_CHAN;
            end
            fpfc_pkg::ST_CHAN: begin
                ch_next = ch_reg + 1'b1;
                if (ch_reg == (CW+1)'(fpfc_pkg::NCH)) begin
                    // last channel goes straight from the corrector into the write word
                    ring_we    = 1'b1;
                    ring_wdata = {corr, new_reg[71:0]};
                    if (slot_reg == SW'(fpfc_pkg::WINDOW - 1)) slot_next = '0;
                    else slot_next = slot_reg + 1'b1;
                    state_next = fpfc_pkg::ST_DIVX;
                end
            end
            fpfc_pkg::ST_DIVX: begin
                if (ch_reg != '0) begin
                    ch_next = '0;
                    if (total_reg > 25'(fpfc_pkg::COP_MIN_TOTAL)) dreq.start = 1'b1;
                    else state_next = fpfc_pkg::ST_OUT;
                end else if (drsp.done) begin
                    dreq.start = 1'b1;
                    dreq.sign  = ny[25];
                    dreq.num   = numy;
                    state_next = fpfc_pkg::ST_DIVY;
                end
            end
            fpfc_pkg::ST_DIVY: begin
                if (drsp.done) state_next = fpfc_pkg::ST_OUT;
            end
            fpfc_pkg::ST_OUT: begin
                if (!out_valid_reg) state_next = fpfc_pkg::ST_IDLE;
            end
            default: state_next = fpfc_pkg::ST_IDLE;
        endcase
    end

    // state and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= fpfc_pkg::ST_IDLE;
            slot_reg      <= '0;
            clr_reg       <= {1'b1, SW'(0)};
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < fpfc_pkg::NCH; i++) sum_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            clr_reg   <= clr_next;
            ch_reg    <= ch_next;
            if (state_reg == fpfc_pkg::ST_CHAN && ch_reg != '0)
                sum_reg[ch_idx] <= sum_new;
            if (m_tvalid && m_tready) out_valid_reg <= 1'b0;
            if (state_reg == fpfc_pkg::ST_OUT && !out_valid_reg) out_valid_reg <= 1'b1;
        end
        if (accept_in) in_reg <= s_tdata;
        if (state_reg == fpfc_pkg::ST_READ) begin
            old_reg   <= ring_rd;
            total_reg <= '0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            cv_reg    <= 1'b0;
        end
        if (state_reg == fpfc_pkg::ST_CHAN && ch_reg != '0) begin
            new_reg[24*ch_idx +: 24] <= corr;
            f_reg[ch_idx]            <= avg[fpfc_pkg::SUM_W-1] ? 23'd0 : avg[22:0];
            total_reg <= total_reg + (avg[fpfc_pkg::SUM_W-1] ? 25'd0 : 25'(avg[22:0]));
        end
        if (state_reg == fpfc_pkg::ST_DIVX && ch_reg == '0 && drsp.done) begin
            cx_reg <= cx_clamp;
            cv_reg <= 1'b1;
        end
        if (state_reg == fpfc_pkg::ST_DIVY && drsp.done) cy_reg <= cy_clamp;
        // output register, loaded when the previous result beat has gone
        if (state_reg == fpfc_pkg::ST_OUT && !out_valid_reg) begin
            out_data_reg <= {cy_reg, cx_reg, total_reg,
                             f_reg[3], f_reg[2], f_reg[1], f_reg[0]};
            out_user_reg <= cv_reg;
        end
    end

    // result beat
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_user_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ----- tb/foot_pressure_filter_cop_core_tb.sv -----
// testbench for the foot pressure filter core: directed and random load-cell beats
// depends on fpfc_pkg and foot_pressure_filter_cop_core; predicts every result beat and checks it
`timescale 1ns / 100ps

module foot_pressure_filter_cop_core_tb;

    // register indexes
    localparam logic [2:0] REG_ZERO_LF = 3'd0;
    localparam logic [2:0] REG_GAIN_LF = 3'd4;
    localparam int GAIN_ONE = 65536;
    localparam int S24_MAX = 8388607;
    localparam int S24_MIN = -8388608;
    localparam int RX_LONG_HOLD = 400;

    typedef struct packed {
        logic [22:0] f_lf, f_lb, f_rf, f_rb;
        logic [24:0] total;
        logic [17:0] cx;
        logic [16:0] cy;
        logic        cvalid;
    } force_beat_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [23:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [151:0] m_tdata;
    logic         m_tuser;

    // predictor state
    longint        cal_reg [8];
    longint        ring [fpfc_pkg::WINDOW][fpfc_pkg::NCH];
    longint        run_sum [fpfc_pkg::NCH];
    int            slot;
    force_beat_t   expected_forces [$];
    int            n_errors = 0;
    bit            rx_idle_en = 1'b1;
    bit            tx_idle_en = 1'b1;
    int            rx_hold = 0;
    bit            hold_req = 1'b0;
    bit            hold_ack = 1'b0;

    foot_pressure_filter_cop_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // run time limit
    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic longint clip(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // corrected samples, running sums, forces and center of pressure for one beat
    function automatic force_beat_t predict_forces(logic [95:0] raw);
        force_beat_t r;
        longint f [fpfc_pkg::NCH];
        longint total, nx, ny, cx, cy, d, c;
        total = 0;
        cx = 0;
        cy = 0;
        for (int i = 0; i < fpfc_pkg::NCH; i++) begin
            d = longint'($signed(raw[24*i +: 24])) - cal_reg[i];
            c = clip((d * cal_reg[4+i]) >>> 16, S24_MIN, S24_MAX);
            run_sum[i] += c - ring[slot][i];
            ring[slot][i] = c;
            f[i] = run_sum[i] / fpfc_pkg::WINDOW;
            if (f[i] < 0) f[i] = 0;
            total += f[i];
        end
        slot = (slot + 1 >= fpfc_pkg::WINDOW) ? 0 : slot + 1;
        r.cvalid = 1'b0;
        if (total > fpfc_pkg::COP_MIN_TOTAL) begin
            nx = f[0] + f[2] - f[1] - f[3];
            ny = f[0] + f[1] - f[2] - f[3];
            cx = clip(nx * fpfc_pkg::COP_X_UM / total, -fpfc_pkg::COP_X_UM, fpfc_pkg::COP_X_UM);
            cy = clip(ny * fpfc_pkg::COP_Y_UM / total, -fpfc_pkg::COP_Y_UM, fpfc_pkg::COP_Y_UM);
            r.cvalid = 1'b1;
        end
        r.f_lf = f[0][22:0];
        r.f_lb = f[1][22:0];
        r.f_rf = f[2][22:0];
        r.f_rb = f[3][22:0];
        r.total = total[24:0];
        r.cx = cx[17:0];
        r.cy = cy[16:0];
        return r;
    endfunction

    // valid stays high between beats unless an idle burst is taken
    task automatic send_samples(logic [95:0] raw);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= raw;
        do @(posedge aclk); while (!s_tready);
        expected_forces.insert(expected_forces.size(), predict_forces(raw));
    endtask

    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cal_reg[idx] = longint'($signed(val));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_forces.size() != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    task automatic set_cal(logic [23:0] z [4], logic [23:0] g [4]);
        drain();
        for (int i = 0; i < fpfc_pkg::NCH; i++) begin
            write_reg(REG_ZERO_LF + 3'(i), z[i]);
            write_reg(REG_GAIN_LF + 3'(i), g[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [95:0] rand_raw(int mode);
        logic [95:0] v;
        for (int i = 0; i < fpfc_pkg::NCH; i++) begin
            case (mode)
                0: v[24*i +: 24] = 24'($urandom);
                1: v[24*i +: 24] = 24'($urandom_range(0, 200000));
                default: v[24*i +: 24] = 24'($urandom_range(0, 3000));
            endcase
        end
        return v;
    endfunction

    // extremes of the samples, negative averages, saturation and threshold edge
    task automatic test_directed();
        logic [23:0] z [4];
        logic [23:0] g [4];
        send_samples('0);
        send_samples({4{24'h7FFFFF}});
        send_samples({4{24'h800000}});
        send_samples({24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF});
        send_samples({24'h000100, 24'h000000, 24'h000000, 24'h000000});
        for (int k = 0; k < 8; k++) send_samples({24'd0, 24'd0, 24'd0, 24'd258});
        send_samples({24'd0, 24'd0, 24'd0, 24'd257});
        for (int k = 0; k < 4; k++) send_samples({4{24'hFFFFFF}});
        // strong gain to force saturation both ways
        z = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'h000010};
        g = '{24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000};
        set_cal(z, g);
        send_samples({24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000});
        send_samples({24'h000000, 24'h000001, 24'h7FFFFF, 24'h800000});
        send_samples({24'h123456, 24'hFEDCBA, 24'h000000, 24'hFFFFFF});
    endtask

    // random beats under several calibrations
    task automatic test_random_cal(int n);
        logic [23:0] z [4];
        logic [23:0] g [4];
        for (int ph = 0; ph < 4; ph++) begin
            for (int i = 0; i < fpfc_pkg::NCH; i++) begin
                z[i] = (ph == 0) ? 24'd0 : (ph == 3) ? 24'($urandom) : 24'($urandom_range(0, 500));
                g[i] = (ph == 0) ? 24'(GAIN_ONE) : (ph == 3) ? 24'($urandom)
                                 : 24'($urandom_range(GAIN_ONE / 2, 4 * GAIN_ONE));
            end
            set_cal(z, g);
            for (int k = 0; k < n; k++) send_samples(rand_raw($urandom_range(0, 2)));
        end
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_backpressure();
        hold_req = ~hold_req;
        for (int k = 0; k < 20; k++) send_samples(rand_raw(1));
    endtask

    // no idling at the end, default calibration restored
    task automatic test_streaming(int n);
        logic [23:0] z [4];
        logic [23:0] g [4];
        z = '{default: 24'd0};
        g = '{default: 24'(GAIN_ONE)};
        set_cal(z, g);
        rx_idle_en = 1'b0;
        tx_idle_en = 1'b0;
        for (int k = 0; k < n; k++) send_samples(rand_raw($urandom_range(1, 2)));
    endtask

    // result receiver, long hold counted here
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            m_tready <= 1'b0;
            rx_hold <= RX_LONG_HOLD;
        end else if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
            m_tready <= 1'b0;
            rx_hold <= $urandom_range(0, 3);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin
        force_beat_t exp_b;
        force_beat_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.f_lf   = m_tdata[22:0];
            got.f_lb   = m_tdata[45:23];
            got.f_rf   = m_tdata[68:46];
            got.f_rb   = m_tdata[91:69];
            got.total  = m_tdata[116:92];
            got.cx     = m_tdata[134:117];
            got.cy     = m_tdata[151:135];
            got.cvalid = m_tuser;
            if (expected_forces.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, got);
                n_errors++;
            end else begin
                exp_b = expected_forces.pop_front();
                if (got.f_lf !== exp_b.f_lf || got.f_lb !== exp_b.f_lb
                    || got.f_rf !== exp_b.f_rf || got.f_rb !== exp_b.f_rb
                    || got.total !== exp_b.total || got.cx !== exp_b.cx
                    || got.cy !== exp_b.cy || got.cvalid !== exp_b.cvalid) begin
                    $display("%0t: mismatch expected lf %0d lb %0d rf %0d rb %0d tot %0d x %0d y %0d v %0b",
                             $time, exp_b.f_lf, exp_b.f_lb, exp_b.f_rf, exp_b.f_rb, exp_b.total,
                             $signed(exp_b.cx), $signed(exp_b.cy), exp_b.cvalid);
                    $display("%0t:          actual   lf %0d lb %0d rf %0d rb %0d tot %0d x %0d y %0d v %0b",
                             $time, got.f_lf, got.f_lb, got.f_rf, got.f_rb, got.total,
                             $signed(got.cx), $signed(got.cy), got.cvalid);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < fpfc_pkg::NCH; i++) begin
            cal_reg[i] = 0;
            cal_reg[4+i] = GAIN_ONE;
            run_sum[i] = 0;
            for (int w = 0; w < fpfc_pkg::WINDOW; w++) ring[w][i] = 0;
        end
        slot = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_cal(230);
        test_backpressure();
        test_streaming(180);
        drain();
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
